// ===== hdl/tcse_pkg.sv =====
`default_nettype none

package tcse_pkg;

    // Default store size in cells.
    localparam int DEF_BUFFER_CELLS = 16384;

    // Arithmetic on cursor and origin wraps at 32 bits.
    localparam int DW = 32;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 14;
    localparam int POS_W      = 14;
    localparam int CELL_W     = 16;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 6;
    localparam int TAB_W      = 8;
    localparam int ATTR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PROD_W     = COL_W + ROW_W;

    localparam logic [COL_W-1:0]  RST_COLUMNS   = 8'd80;
    localparam logic [ROW_W-1:0]  RST_ROWS      = 6'd25;
    localparam logic [TAB_W-1:0]  RST_TAB_WIDTH = 8'd8;
    localparam logic [ATTR_W-1:0] RST_ATTRIBUTE = 8'd7;
    localparam logic [CELL_W-1:0] RESET_CELL    = 16'h0720;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // Remainder unit: four dividend bits per cycle.
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = DW / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int DIVISOR_W      = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS   = 2'd0,
        CFG_ROWS      = 2'd1,
        CFG_TAB_WIDTH = 2'd2,
        CFG_ATTRIBUTE = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CLS_CR,
        CLS_BS,
        CLS_LF,
        CLS_TAB,
        CLS_PRINT
    } ch_class_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_INIT_WR,
        CMD_LOAD,
        CMD_DIV_USABLE,
        CMD_SET_USABLE,
        CMD_DIV_CUR,
        CMD_DIV_LF,
        CMD_DIV_X,
        CMD_DIV_TAB,
        CMD_DIV_SCROLL,
        CMD_ROUND_CUR,
        CMD_BS_APPLY,
        CMD_SET_X,
        CMD_TAB_SET,
        CMD_PUT_WR,
        CMD_WRAP_START,
        CMD_COPY_RD,
        CMD_COPY_WR,
        CMD_SET_TOP,
        CMD_CLR_START,
        CMD_FILL_WR,
        CMD_READ,
        CMD_READ_CAP,
        CMD_EMIT
    } cmd_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_USE,
        ST_USE_WAIT,
        ST_PUT,
        ST_CR_WAIT,
        ST_BS_WAIT,
        ST_LF_WAIT,
        ST_TABX_WAIT,
        ST_TABN,
        ST_TABN_WAIT,
        ST_WRAP_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SCROLL_CHK,
        ST_SCROLL_WAIT,
        ST_FILL,
        ST_CLR,
        ST_READ,
        ST_READ_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic      div_done;
        op_t       op;
        ch_class_t ch;
        logic      nx_ge_cx;
        logic      cur_ge_usable;
        logic      need_scroll;
        logic      fill_go;
        logic      copy_last;
        logic      init_last;
        logic      out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/tcse_rem.sv =====
`default_nettype none

module tcse_rem
    import tcse_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DW-1:0]        dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [DIVISOR_W-1:0]      rem
);

    logic [DW-1:0]        dvd_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIV_CNT_W-1:0] step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // Restoring remainder, one bit per inner step; the partial remainder
    // always stays below the divisor.
    always_comb begin
        logic [DIVISOR_W:0]   r9;
        logic [DIVISOR_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            r9 = {r, dvd_reg[DW-1-k]};
            if (r9 >= {1'b0, div_reg}) begin
                r9 = r9 - {1'b0, div_reg};
            end
            r = r9[DIVISOR_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << DIV_RADIX_BITS;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/tcse_ctrl.sv =====
`default_nettype none

module tcse_ctrl
    import tcse_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd = CMD_INIT_WR;
                if (status.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = ST_USE;
                end
            end
            ST_USE: begin
                cmd        = CMD_DIV_USABLE;
                state_next = ST_USE_WAIT;
            end
            ST_USE_WAIT: begin
                if (status.div_done) begin
                    cmd = CMD_SET_USABLE;
                    case (status.op)
                        OP_PUT:   state_next = ST_PUT;
                        OP_READ:  state_next = ST_READ;
                        OP_CLEAR: state_next = ST_CLR;
                        default:  state_next = ST_RESULT;
                    endcase
                end
            end
            ST_PUT: begin
                case (status.ch)
                    CLS_CR: begin
                        cmd        = CMD_DIV_CUR;
                        state_next = ST_CR_WAIT;
                    end
                    CLS_BS: begin
                        cmd        = CMD_DIV_CUR;
                        state_next = ST_BS_WAIT;
                    end
                    CLS_LF: begin
                        cmd        = CMD_DIV_LF;
                        state_next = ST_LF_WAIT;
                    end
                    CLS_TAB: begin
                        cmd        = CMD_DIV_X;
                        state_next = ST_TABX_WAIT;
                    end
                    default: begin
                        cmd        = CMD_PUT_WR;
                        state_next = ST_WRAP_CHK;
                    end
                endcase
            end
            ST_CR_WAIT: begin
                if (status.div_done) begin
                    cmd        = CMD_ROUND_CUR;
                    state_next = ST_RESULT;
                end
            end
            ST_BS_WAIT: begin
                if (status.div_done) begin
                    cmd        = CMD_BS_APPLY;
                    state_next = ST_RESULT;
                end
            end
            ST_LF_WAIT: begin
                if (status.div_done) begin
                    cmd        = CMD_ROUND_CUR;
                    state_next = ST_WRAP_CHK;
                end
            end
            ST_TABX_WAIT: begin
                if (status.div_done) begin
                    cmd        = CMD_SET_X;
                    state_next = ST_TABN;
                end
            end
            ST_TABN: begin
                cmd        = CMD_DIV_TAB;
                state_next = ST_TABN_WAIT;
            end
            ST_TABN_WAIT: begin
                if (status.div_done) begin
                    if (status.nx_ge_cx) begin
                        cmd        = CMD_DIV_LF;
                        state_next = ST_LF_WAIT;
                    end else begin
                        cmd        = CMD_TAB_SET;
                        state_next = ST_WRAP_CHK;
                    end
                end
            end
            ST_WRAP_CHK: begin
                if (status.cur_ge_usable) begin
                    cmd        = CMD_WRAP_START;
                    state_next = ST_COPY_RD;
                end else begin
                    state_next = ST_SCROLL_CHK;
                end
            end
            ST_COPY_RD: begin
                cmd        = CMD_COPY_RD;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                cmd = CMD_COPY_WR;
                if (status.copy_last) begin
                    state_next = ST_SCROLL_CHK;
                end else begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_SCROLL_CHK: begin
                if (status.need_scroll) begin
                    cmd        = CMD_DIV_SCROLL;
                    state_next = ST_SCROLL_WAIT;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SCROLL_WAIT: begin
                if (status.div_done) begin
                    cmd        = CMD_SET_TOP;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (status.fill_go) begin
                    cmd = CMD_FILL_WR;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_CLR: begin
                cmd        = CMD_CLR_START;
                state_next = ST_FILL;
            end
            ST_READ: begin
                cmd        = CMD_READ;
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                cmd        = CMD_READ_CAP;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd        = CMD_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tcse_dp.sv =====
`default_nettype none

module tcse_dp
    import tcse_pkg::*;
#(
    parameter int BUFFER_CELLS = DEF_BUFFER_CELLS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [OP_W-1:0]       s_operation,
    input  wire logic [CHAR_W-1:0]     s_char_code,
    input  wire logic [IDX_W-1:0]      s_cell_index,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output logic [POS_W-1:0]           m_cursor_pos,
    output logic [POS_W-1:0]           m_origin,
    output logic [CELL_W-1:0]          m_cell_data,
    input  wire cmd_t                  cmd,
    output status_t                    status
);

    localparam int AW = $clog2(BUFFER_CELLS);
    localparam int UW = $clog2(BUFFER_CELLS + 1);
    localparam logic [DW-1:0] BUF32 = DW'(BUFFER_CELLS);

    // Configuration
    logic [COL_W-1:0]  columns_reg, columns_next;
    logic [ROW_W-1:0]  rows_reg, rows_next;
    logic [TAB_W-1:0]  tab_reg, tab_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;

    // Current word
    logic [OP_W-1:0]   op_reg, op_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Terminal state and scratch
    logic [DW-1:0]     cursor_reg, cursor_next;
    logic [DW-1:0]     top_reg, top_next;
    logic [UW-1:0]     usable_reg, usable_next;
    logic [UW-1:0]     screen_reg, screen_next;
    logic [DW-1:0]     dvd_reg, dvd_next;
    logic [COL_W-1:0]  x_reg, x_next;
    logic [DW-1:0]     base_reg, base_next;
    logic [DW-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]     end_reg, end_next;
    logic              rd_zero_reg, rd_zero_next;
    logic [CELL_W-1:0] data_reg, data_next;

    // Result register
    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  m_cursor_reg, m_cursor_next;
    logic [POS_W-1:0]  m_origin_reg, m_origin_next;
    logic [CELL_W-1:0] m_data_reg, m_data_next;

    // Store
    logic [CELL_W-1:0] mem [BUFFER_CELLS];
    logic [CELL_W-1:0] mem_q_reg;
    logic              mem_we;
    logic              mem_re;
    logic [DW-1:0]     mem_waddr;
    logic [DW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    // Remainder unit
    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_busy;
    logic                 div_done;
    logic [DIVISOR_W-1:0] div_rem;

    logic [COL_W-1:0]  cx;
    logic [ROW_W-1:0]  ry;
    logic [TAB_W-1:0]  tw;
    logic [PROD_W-1:0] prod;
    logic [DW-1:0]     usable32;
    logic [DW-1:0]     screen32;
    logic [DW-1:0]     rem32;
    logic [DW-1:0]     rounded;
    logic [DW-1:0]     usable_new32;
    logic [DW-1:0]     screen_new32;
    logic [DW-1:0]     copy_src;
    logic [DW-1:0]     idx32;
    logic [CELL_W-1:0] blank_cell;
    logic [CELL_W-1:0] copy_cell;
    logic              out_free;
    ch_class_t         ch_class;

    tcse_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign cx   = (columns_reg == '0) ? COL_W'(1) : columns_reg;
    assign ry   = (rows_reg == '0) ? ROW_W'(1) : rows_reg;
    assign tw   = (tab_reg == '0) ? TAB_W'(1) : tab_reg;
    assign prod = PROD_W'(cx) * PROD_W'(ry);

    assign usable32     = DW'(usable_reg);
    assign screen32     = DW'(screen_reg);
    assign rem32        = DW'(div_rem);
    assign rounded      = dvd_reg - rem32;
    assign usable_new32 = BUF32 - rem32;
    assign screen_new32 = (DW'(prod) < usable_new32) ? DW'(prod) : usable_new32;
    assign copy_src     = top_reg + cnt_reg;
    assign idx32        = DW'(idx_reg);
    assign blank_cell   = {attr_reg, CH_SPACE};
    assign copy_cell    = rd_zero_reg ? '0 : mem_q_reg;
    assign out_free     = !m_valid_reg || m_ready;

    always_comb begin
        case (char_reg)
            CH_CR:   ch_class = CLS_CR;
            CH_BS:   ch_class = CLS_BS;
            CH_LF:   ch_class = CLS_LF;
            CH_TAB:  ch_class = CLS_TAB;
            default: ch_class = CLS_PRINT;
        endcase
    end

    always_comb begin
        status.div_done      = div_done;
        status.op            = op_t'(op_reg);
        status.ch            = ch_class;
        status.nx_ge_cx      = rounded >= DW'(cx);
        status.cur_ge_usable = cursor_reg >= usable32;
        status.need_scroll   = cursor_reg >= (top_reg + screen32);
        status.fill_go       = (cnt_reg < end_reg) && (cnt_reg < BUF32);
        status.copy_last     = (cnt_reg + DW'(1)) == screen32;
        status.init_last     = cnt_reg == (BUF32 - DW'(1));
        status.out_free      = out_free;
    end

    // Remainder unit operands
    always_comb begin
        div_start    = 1'b1;
        div_dividend = cursor_reg;
        div_divisor  = cx;
        case (cmd)
            CMD_DIV_USABLE: div_dividend = BUF32;
            CMD_DIV_CUR:    div_dividend = cursor_reg;
            CMD_DIV_LF:     div_dividend = cursor_reg + DW'(cx);
            CMD_DIV_X:      div_dividend = cursor_reg - top_reg;
            CMD_DIV_TAB: begin
                div_dividend = DW'(x_reg) + DW'(tw);
                div_divisor  = tw;
            end
            CMD_DIV_SCROLL: div_dividend = cursor_reg - screen32 + DW'(cx);
            default:        div_start = 1'b0;
        endcase
    end

    // Store port control
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = cnt_reg;
        mem_raddr = copy_src;
        mem_wdata = blank_cell;
        case (cmd)
            CMD_INIT_WR: begin
                mem_we    = 1'b1;
                mem_wdata = RESET_CELL;
            end
            CMD_PUT_WR: begin
                mem_we    = cursor_reg < BUF32;
                mem_waddr = cursor_reg;
                mem_wdata = {attr_reg, char_reg};
            end
            CMD_COPY_WR: begin
                mem_we    = 1'b1;
                mem_wdata = copy_cell;
            end
            CMD_FILL_WR: mem_we = 1'b1;
            CMD_COPY_RD: mem_re = 1'b1;
            CMD_READ: begin
                mem_re    = 1'b1;
                mem_raddr = idx32;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr[AW-1:0]];
        end
    end

    // Register updates
    always_comb begin
        columns_next  = columns_reg;
        rows_next     = rows_reg;
        tab_next      = tab_reg;
        attr_next     = attr_reg;
        op_next       = op_reg;
        char_next     = char_reg;
        idx_next      = idx_reg;
        cursor_next   = cursor_reg;
        top_next      = top_reg;
        usable_next   = usable_reg;
        screen_next   = screen_reg;
        dvd_next      = div_start ? div_dividend : dvd_reg;
        x_next        = x_reg;
        base_next     = base_reg;
        cnt_next      = cnt_reg;
        end_next      = end_reg;
        rd_zero_next  = rd_zero_reg;
        data_next     = data_reg;
        m_valid_next  = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_cursor_next = m_cursor_reg;
        m_origin_next = m_origin_reg;
        m_data_next   = m_data_reg;

        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLUMNS:   columns_next = cfg_wdata;
                CFG_ROWS:      rows_next    = cfg_wdata[ROW_W-1:0];
                CFG_TAB_WIDTH: tab_next     = cfg_wdata;
                CFG_ATTRIBUTE: attr_next    = cfg_wdata;
                default: ;
            endcase
        end

        case (cmd)
            CMD_INIT_WR: cnt_next = cnt_reg + DW'(1);
            CMD_LOAD: begin
                op_next   = s_operation;
                char_next = s_char_code;
                idx_next  = s_cell_index;
                data_next = '0;
            end
            CMD_SET_USABLE: begin
                usable_next = UW'(usable_new32);
                screen_next = UW'(screen_new32);
            end
            CMD_ROUND_CUR: cursor_next = rounded;
            CMD_BS_APPLY: begin
                if (div_rem != '0) begin
                    cursor_next = cursor_reg - DW'(1);
                end
            end
            CMD_SET_X: begin
                x_next    = div_rem;
                base_next = top_reg + rounded;
            end
            CMD_TAB_SET: cursor_next = base_reg + rounded;
            CMD_PUT_WR:  cursor_next = cursor_reg + DW'(1);
            CMD_WRAP_START: begin
                cursor_next = cursor_reg - usable32 + screen32;
                cnt_next    = '0;
            end
            CMD_COPY_RD: rd_zero_next = copy_src >= BUF32;
            CMD_COPY_WR: begin
                cnt_next = cnt_reg + DW'(1);
                if (status.copy_last) begin
                    top_next = '0;
                end
            end
            CMD_SET_TOP: begin
                top_next = rounded;
                cnt_next = top_reg + screen32;
                end_next = (rounded > top_reg) ? (rounded + screen32) : '0;
            end
            CMD_CLR_START: begin
                cursor_next = '0;
                top_next    = '0;
                cnt_next    = '0;
                end_next    = screen32;
            end
            CMD_FILL_WR:  cnt_next = cnt_reg + DW'(1);
            CMD_READ:     rd_zero_next = idx32 >= BUF32;
            CMD_READ_CAP: data_next = copy_cell;
            CMD_EMIT: begin
                m_valid_next  = 1'b1;
                m_cursor_next = cursor_reg[POS_W-1:0];
                m_origin_next = top_reg[POS_W-1:0];
                m_data_next   = data_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= RST_COLUMNS;
            rows_reg    <= RST_ROWS;
            tab_reg     <= RST_TAB_WIDTH;
            attr_reg    <= RST_ATTRIBUTE;
            cursor_reg  <= '0;
            top_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
            tab_reg     <= tab_next;
            attr_reg    <= attr_next;
            cursor_reg  <= cursor_next;
            top_reg     <= top_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        char_reg     <= char_next;
        idx_reg      <= idx_next;
        usable_reg   <= usable_next;
        screen_reg   <= screen_next;
        dvd_reg      <= dvd_next;
        x_reg        <= x_next;
        base_reg     <= base_next;
        end_reg      <= end_next;
        rd_zero_reg  <= rd_zero_next;
        data_reg     <= data_next;
        m_cursor_reg <= m_cursor_next;
        m_origin_reg <= m_origin_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_cursor_reg;
    assign m_origin     = m_origin_reg;
    assign m_cell_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr < BUF32))
        else $error("store write outside the buffer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("remainder unit restarted while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_EMIT) |-> out_free)
        else $error("result register overwritten before it was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_SET_USABLE) |=> ((screen_reg <= usable_reg) && (screen_reg != '0)))
        else $error("screen size out of range");

endmodule

`default_nettype wire

// ===== hdl/text_console_scroll_engine_unit.sv =====
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_operation, s_char_code, s_cell_index
// m_       out        m_valid/m_ready    m_cursor_pos, m_origin, m_cell_data
// cfg_     in         cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// After reset the store is filled with blank cells, one cell per cycle, and no
// word is taken until the fill is done; configuration writes are taken then.
// One word is processed at a time. Each word starts with a pass of the
// remainder unit that finds the usable buffer end. A scroll blanks the cells
// that come into view, a wrap copies the screen cells to the store start,
// each with a read and then a write, and a clear blanks every screen cell.
// A waiting result does not block the next word, but a second result waits
// until the first has been taken.
`default_nettype none

module text_console_scroll_engine_unit
    import tcse_pkg::*;
#(
    parameter int BUFFER_CELLS = DEF_BUFFER_CELLS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OP_W-1:0]       s_operation,
    input  wire logic [CHAR_W-1:0]     s_char_code,
    input  wire logic [IDX_W-1:0]      s_cell_index,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [POS_W-1:0]           m_cursor_pos,
    output logic [POS_W-1:0]           m_origin,
    output logic [CELL_W-1:0]          m_cell_data
);

    // The controller sequences each word as a series of datapath commands;
    // the datapath reports comparisons and handshake state back to it.
    cmd_t    cmd;
    status_t status;

    tcse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, cursor and origin, the cell
    // store, the shared remainder unit and the result register.
    tcse_dp #(
        .BUFFER_CELLS (BUFFER_CELLS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_operation  (s_operation),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_cursor_pos (m_cursor_pos),
        .m_origin     (m_origin),
        .m_cell_data  (m_cell_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== tb/tcse_console_checker.sv =====
`default_nettype none

module tcse_console_checker
    import tcse_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [OP_W-1:0]       s_operation,
    input  wire logic [CHAR_W-1:0]     s_char_code,
    input  wire logic [IDX_W-1:0]      s_cell_index,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [POS_W-1:0]      m_cursor_pos,
    input  wire logic [POS_W-1:0]      m_origin,
    input  wire logic [CELL_W-1:0]     m_cell_data,
    output int                         failures,
    output int                         pending
);

    localparam int unsigned CELLS = DEF_BUFFER_CELLS;

    typedef struct {
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  origin;
        logic [CELL_W-1:0] cell_data;
    } console_word_t;

    logic [CELL_W-1:0] shadow_store [0:CELLS-1];
    int unsigned cur_pos;
    int unsigned top_cell;
    logic [COL_W-1:0]  columns;
    logic [ROW_W-1:0]  rows;
    logic [TAB_W-1:0]  tab_width;
    logic [ATTR_W-1:0] attribute;
    console_word_t expected_words [$];
    int mismatch_count = 0;
    int pending_count = 0;
    bit store_cleared = 0;

    assign failures = mismatch_count;
    assign pending  = pending_count;

    function automatic int unsigned at_least_one(int unsigned v);
        return (v != 0) ? v : 1;
    endfunction

    function automatic int unsigned floor_to(int unsigned v, int unsigned m);
        return v - (v % m);
    endfunction

    function automatic int unsigned ceil_to(int unsigned v, int unsigned m);
        return floor_to(v + m - 1, m);
    endfunction

    function automatic logic [CELL_W-1:0] load_cell(int unsigned i);
        return (i < CELLS) ? shadow_store[i] : '0;
    endfunction

    function automatic void store_cell(int unsigned i, logic [CELL_W-1:0] v);
        if (i < CELLS) shadow_store[i] = v;
    endfunction

    function automatic void screen_geometry(output int unsigned cx, output int unsigned usable,
                                            output int unsigned screen);
        cx = at_least_one(columns);
        usable = floor_to(CELLS, cx);
        screen = cx * at_least_one(rows);
        if (screen > usable) screen = usable;
    endfunction

    // Cursor motion, wrap to the store start and scrolling for one put.
    function automatic void advance_console(logic [CHAR_W-1:0] c);
        int unsigned cx, usable, screen, x, nx, prev;
        logic [CELL_W-1:0] blank;
        screen_geometry(cx, usable, screen);
        x = (cur_pos - top_cell) % cx;
        if (c == CH_CR) begin
            cur_pos = floor_to(cur_pos, cx);
            return;
        end
        if (c == CH_BS) begin
            if (cur_pos != floor_to(cur_pos, cx)) cur_pos--;
            return;
        end
        if (c == CH_LF) begin
            cur_pos = ceil_to(cur_pos + 1, cx);
        end else if (c == CH_TAB) begin
            nx = ceil_to(x + 1, at_least_one(tab_width));
            if (nx >= cx) cur_pos = ceil_to(cur_pos + 1, cx);
            else cur_pos = top_cell + floor_to(cur_pos - top_cell, cx) + nx;
        end else begin
            store_cell(cur_pos, {attribute, c});
            cur_pos++;
        end
        if (cur_pos >= usable) begin
            cur_pos -= usable;
            for (int unsigned i = 0; i < screen; i++) store_cell(i, load_cell(top_cell + i));
            cur_pos += screen;
            top_cell = 0;
        end
        prev = top_cell;
        if (cur_pos >= top_cell + screen) top_cell = ceil_to(cur_pos - screen + 1, cx);
        if (top_cell > prev) begin
            blank = {attribute, CH_SPACE};
            for (int unsigned i = prev + screen; i < top_cell + screen; i++) store_cell(i, blank);
        end
    endfunction

    function automatic void clear_console();
        int unsigned cx, usable, screen;
        screen_geometry(cx, usable, screen);
        cur_pos = 0;
        top_cell = 0;
        for (int unsigned i = 0; i < screen; i++) store_cell(i, {attribute, CH_SPACE});
    endfunction

    function automatic console_word_t predict_word(op_t op, logic [CHAR_W-1:0] ch,
                                                    logic [IDX_W-1:0] idx);
        console_word_t w;
        w.cell_data = '0;
        case (op)
            OP_PUT:   advance_console(ch);
            OP_READ:  w.cell_data = load_cell(idx);
            OP_CLEAR: clear_console();
            default:  ;
        endcase
        w.cursor_pos = cur_pos[POS_W-1:0];
        w.origin     = top_cell[POS_W-1:0];
        return w;
    endfunction

    always @(posedge aclk) begin
        console_word_t want;
        if (!aresetn) begin
            if (!store_cleared) begin
                for (int i = 0; i < CELLS; i++) shadow_store[i] = RESET_CELL;
                store_cleared = 1;
            end
            cur_pos = 0;
            top_cell = 0;
            columns = RST_COLUMNS;
            rows = RST_ROWS;
            tab_width = RST_TAB_WIDTH;
            attribute = RST_ATTRIBUTE;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_COLUMNS:   columns = cfg_wdata;
                    CFG_ROWS:      rows = cfg_wdata[ROW_W-1:0];
                    CFG_TAB_WIDTH: tab_width = cfg_wdata;
                    CFG_ATTRIBUTE: attribute = cfg_wdata;
                    default:       ;
                endcase
            end
            if (s_valid && s_ready)
                expected_words.push_back(predict_word(op_t'(s_operation), s_char_code,
                                                      s_cell_index));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected word: cursor %0d origin %0d data %h",
                                 m_cursor_pos, m_origin, m_cell_data);
                end else begin
                    want = expected_words.pop_front();
                    if (want.cursor_pos !== m_cursor_pos || want.origin !== m_origin ||
                        want.cell_data !== m_cell_data) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"Mismatch: expected cursor %0d origin %0d data %h,",
                                      " got %0d %0d %h"},
                                     want.cursor_pos, want.origin, want.cell_data,
                                     m_cursor_pos, m_origin, m_cell_data);
                    end
                end
            end
        end
        pending_count = expected_words.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb_text_console_scroll_engine_unit.sv =====
`default_nettype none

module tb_text_console_scroll_engine_unit;
    import tcse_pkg::*;

    // Longest quiet stretch allowed: a wrap of the largest screen reads and then
    // writes every screen cell and may be followed by a full row of blanking.
    localparam int QUIET_LIMIT = 200000;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic [OP_W-1:0] s_operation = '0;
    logic [CHAR_W-1:0] s_char_code = '0;
    logic [IDX_W-1:0] s_cell_index = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [POS_W-1:0] m_cursor_pos;
    logic [POS_W-1:0] m_origin;
    logic [CELL_W-1:0] m_cell_data;

    int failures;
    int pending;

    // Requests from the stimulus to the receiver, written only with
    // nonblocking assignments so that both processes see them the same way.
    bit no_idle = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    text_console_scroll_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_char_code(s_char_code), .s_cell_index(s_cell_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_cursor_pos(m_cursor_pos),
        .m_origin(m_origin), .m_cell_data(m_cell_data)
    );

    tcse_console_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_char_code(s_char_code), .s_cell_index(s_cell_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_cursor_pos(m_cursor_pos),
        .m_origin(m_origin), .m_cell_data(m_cell_data),
        .failures(failures), .pending(pending)
    );

    // The receiver serves a requested long hold-off (the block parks one word,
    // holds one more and stops taking more), else stalls at random unless no_idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else if (hold_left > 0) begin
            m_ready <= 0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left <= 300;
            m_ready <= 0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 14);
        end
    end

    // The watchdog ends the run when no word moves on either channel for
    // too long, which also covers a block that never leaves its clearing pass.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word and hold it steady until it is taken. Called at a rising
    // edge; an optional idle gap follows the handshake.
    task automatic send_word(op_t op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        s_valid <= 1;
        s_operation <= op;
        s_char_code <= ch;
        s_cell_index <= idx;
        do @(posedge aclk); while (!s_ready);
        if (!no_idle && $urandom_range(99) < 14) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Stop offering words and wait until every predicted word has come back.
    // A few extra cycles let the block return to idle before register writes.
    task automatic drain();
        if (s_valid) s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Registers are written back to back, one per cycle, while the block idles.
    task automatic set_config(logic [7:0] cols, logic [7:0] nrows, logic [7:0] tab,
                              logic [7:0] attr);
        cfg_wr_en <= 1;
        cfg_index <= CFG_COLUMNS;
        cfg_wdata <= cols;
        @(posedge aclk);
        cfg_index <= CFG_ROWS;
        cfg_wdata <= nrows;
        @(posedge aclk);
        cfg_index <= CFG_TAB_WIDTH;
        cfg_wdata <= tab;
        @(posedge aclk);
        cfg_index <= CFG_ATTRIBUTE;
        cfg_wdata <= attr;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    // Random traffic: mostly puts, with newlines weighted by lf_pct so that
    // the cursor sweeps the store, scrolls and eventually wraps to cell 0.
    // Reads, clears and the unused operation code make up the rest.
    task automatic run_random(int count, int lf_pct, bit hold_midway, bit pause_midway);
        int pick;
        int code;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < count; k++) begin
            if (hold_midway && k == count / 3) hold_requests <= hold_requests + 1;
            if (pause_midway && k == count / 2) drain();
            pick = $urandom_range(99);
            code = $urandom_range(99);
            if (code < lf_pct) ch = CH_LF;
            else if (code < lf_pct + 8) ch = CH_TAB;
            else if (code < lf_pct + 12) ch = CH_CR;
            else if (code < lf_pct + 16) ch = CH_BS;
            else ch = CHAR_W'($urandom_range(255));
            idx = ($urandom_range(1) != 0) ? IDX_W'($urandom_range(16383))
                                           : IDX_W'($urandom_range(1023));
            if (pick < 82) send_word(OP_PUT, ch, idx);
            else if (pick < 95) send_word(OP_READ, ch, idx);
            else if (pick < 97) send_word(OP_CLEAR, ch, idx);
            else send_word(OP_NONE, ch, idx);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed words at the reset settings: plain and extreme character
        // codes, backspace inside a row and at its start, carriage return,
        // tabs up to and past the row end, newline, reads across the index
        // bits, the unused code and a clear.
        send_word(OP_PUT, 8'h48, '0);
        send_word(OP_PUT, 8'h00, '0);
        send_word(OP_PUT, 8'hFF, '0);
        send_word(OP_PUT, CH_BS, '0);
        send_word(OP_PUT, CH_CR, '0);
        send_word(OP_PUT, CH_BS, '0);
        for (int k = 0; k < 10; k++) send_word(OP_PUT, CH_TAB, '0);
        send_word(OP_PUT, CH_LF, '0);
        send_word(OP_READ, '0, 14'd0);
        send_word(OP_READ, '0, 14'd1);
        send_word(OP_READ, '0, 14'h3FFF);
        send_word(OP_READ, 8'hFF, 14'h2AAA);
        send_word(OP_READ, '0, 14'h1555);
        send_word(OP_NONE, 8'h55, 14'h3FFF);
        send_word(OP_CLEAR, 8'hAA, '0);
        send_word(OP_READ, '0, 14'd0);
        drain();

        // Zero registers behave as one; the extremes follow, and the cursor
        // and origin are kept across every change, so some settings leave
        // them off the row grid.
        set_config(8'd0, 8'd0, 8'd0, 8'hFF);
        run_random(60, 10, 0, 0);
        drain();
        set_config(8'd1, 8'd1, 8'd1, 8'h00);
        run_random(60, 10, 0, 0);
        drain();
        set_config(8'd255, 8'd60, 8'd255, 8'h5A);
        run_random(50, 30, 0, 0);
        drain();
        set_config(8'd255, 8'd3, 8'd7, 8'hA5);
        run_random(160, 45, 1, 0);
        drain();
        set_config(8'd40, 8'd10, 8'd4, 8'h1F);
        run_random(150, 35, 1, 1);
        drain();
        set_config(8'd13, 8'd60, 8'd3, 8'hC3);
        run_random(120, 30, 0, 0);
        drain();
        set_config(8'd200, 8'd5, 8'd16, 8'h3C);
        run_random(150, 40, 0, 1);
        drain();

        // A long stretch with neither side idling.
        no_idle <= 1;
        set_config(8'd80, 8'd25, 8'd8, 8'h07);
        run_random(150, 35, 0, 0);
        drain();

        repeat (50) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== text_console_scroll_engine_unit.f =====
hdl/tcse_pkg.sv
hdl/tcse_rem.sv
hdl/tcse_ctrl.sv
hdl/tcse_dp.sv
hdl/text_console_scroll_engine_unit.sv
tb/tcse_console_checker.sv
tb/tb_text_console_scroll_engine_unit.sv
